FILE: rtl/ppsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Polar palette spiral color package
// Shared constants, types and tables for the spiral color pipeline.
// ----------------------------------------------------------------------------
package ppsc_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int PALETTE_SIZE   = 6;
  localparam int COLOR_W        = 24;
  localparam int CFG_IDX_W      = 3;
  localparam int CORDIC_STEPS   = 16;
  localparam int ZW             = 20;
  localparam int HALF_PI_Q16    = 102944;
  localparam int K_PHASE        = 187433;
  localparam int K_PHASE_W      = 19;
  localparam int RING_RECIP     = 41943;
  localparam int RING_RECIP_W   = 16;
  localparam int RING_SHIFT     = 20;
  localparam int RING_DIV       = 25;
  localparam int FULL_W         = 44;
  localparam int IP_W           = 10;
  localparam int MOD6_RECIP     = 683;
  localparam int MOD6_RECIP_W   = 10;
  localparam int MOD6_SHIFT     = 12;
  localparam int FRAC_W         = 16;

  localparam logic [FULL_W-1:0] PHASE_BASE = FULL_W'(2001) << 31;
  localparam logic [FULL_W-1:0] RING_STEP  = FULL_W'(10) << 32;
  localparam logic [FULL_W-1:0] PHASE_HALF = FULL_W'(32768);

  typedef logic [COLOR_W-1:0] color_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAL0 = 3'd0,
    REG_PAL1 = 3'd1,
    REG_PAL2 = 3'd2,
    REG_PAL3 = 3'd3,
    REG_PAL4 = 3'd4,
    REG_PAL5 = 3'd5
  } cfg_reg_t;

  localparam color_t PAL_RESET [PALETTE_SIZE] = '{
    24'hFF8888, 24'h88FF88, 24'h8888FF, 24'hFF88FF, 24'h88FFFF, 24'hFFFF88
  };

  function automatic logic signed [ZW-1:0] atan_q16(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:       r = ZW'(51472);
      1:       r = ZW'(30386);
      2:       r = ZW'(16055);
      3:       r = ZW'(8150);
      4:       r = ZW'(4091);
      5:       r = ZW'(2047);
      6:       r = ZW'(1024);
      7:       r = ZW'(512);
      8:       r = ZW'(256);
      9:       r = ZW'(128);
      10:      r = ZW'(64);
      11:      r = ZW'(32);
      12:      r = ZW'(16);
      13:      r = ZW'(8);
      14:      r = ZW'(4);
      default: r = ZW'(2);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ppsc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Polar palette spiral color channels
// Pixel offset input, color output and palette write channels.
// ----------------------------------------------------------------------------
interface ppsc_pix_if #(parameter int COORD_BITS = ppsc_pkg::COORD_BITS_DEF);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x_offset;
  logic signed [COORD_BITS-1:0] y_offset;
  modport source (output valid, x_offset, y_offset, input ready);
  modport sink (input valid, x_offset, y_offset, output ready);
endinterface

interface ppsc_color_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

interface ppsc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [ppsc_pkg::CFG_IDX_W-1:0]      index;
  logic [ppsc_pkg::COLOR_W-1:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/polar_palette_spiral_color.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Polar palette spiral color
// Maps a pixel offset from the image center to a blended palette color.
//
// pix_in carries one signed (x_offset, y_offset) pair per beat; pix_out
// returns one red, green, blue beat for every input beat, in order.
// cfg writes palette entries 0 to 5; the user must write only while the
// pipeline is empty, as the block itself does not enforce it. Other indexes
// are ignored and cfg is always ready. The datapath is a 24-stage pipeline:
// one stage for pre-rotation and squaring, 17 stages that carry the 16
// CORDIC steps and the 12 square root digits, and six stages for phase,
// palette lookup and blending. One beat is taken every cycle while pix_out
// is not stalled. When pix_out is stalled the whole pipeline holds and
// pix_in.ready drops, so nothing is lost or repeated. Reset clears the
// valid bits and restores the default palette.
// ----------------------------------------------------------------------------
module polar_palette_spiral_color #(
  parameter int COORD_BITS = ppsc_pkg::COORD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  ppsc_pix_if.sink     pix_in,
  ppsc_color_if.source pix_out,
  ppsc_cfg_if.sink     cfg
);
  import ppsc_pkg::*;

  localparam int CW  = COORD_BITS + 19;
  localparam int R2W = 2 * COORD_BITS;
  localparam int RTW = COORD_BITS + 3;
  localparam int NL  = CORDIC_STEPS + 1;
  localparam int PW  = ZW + K_PHASE_W;
  localparam int QW  = COORD_BITS + 6;
  localparam int PRW = 26;

  localparam logic signed [K_PHASE_W-1:0] K_PHASE_S = K_PHASE_W'(K_PHASE);

  logic   en;
  color_t pal [PALETTE_SIZE];

  assign en           = !pix_out.valid || pix_out.ready;
  assign pix_in.ready = en;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PALETTE_SIZE; i++) pal[i] <= PAL_RESET[i];
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_PAL0: pal[0] <= cfg.data;
        REG_PAL1: pal[1] <= cfg.data;
        REG_PAL2: pal[2] <= cfg.data;
        REG_PAL3: pal[3] <= cfg.data;
        REG_PAL4: pal[4] <= cfg.data;
        REG_PAL5: pal[5] <= cfg.data;
        default: ;
      endcase
    end
  end

  // Stage A: quadrant pre-rotation and squares.
  logic                  a_v, a_zero;
  logic signed [CW-1:0]  a_px, a_py;
  logic signed [ZW-1:0]  a_z;
  logic [R2W-1:0]        a_xx, a_yy;
  logic signed [CW-1:0]  xs, ys;
  logic signed [R2W-1:0] xsq, ysq;

  assign xs  = {{3{pix_in.x_offset[COORD_BITS-1]}}, pix_in.x_offset, 16'b0};
  assign ys  = {{3{pix_in.y_offset[COORD_BITS-1]}}, pix_in.y_offset, 16'b0};
  assign xsq = pix_in.x_offset * pix_in.x_offset;
  assign ysq = pix_in.y_offset * pix_in.y_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= pix_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_zero <= (pix_in.x_offset == '0) && (pix_in.y_offset == '0);
      a_xx   <= xsq;
      a_yy   <= ysq;
      if (ys[CW-1]) begin
        if (!xs[CW-1]) begin
          a_px <= xs;
          a_py <= -ys;
          a_z  <= ZW'(HALF_PI_Q16);
        end else begin
          a_px <= -xs;
          a_py <= ys;
          a_z  <= -ZW'(HALF_PI_Q16);
        end
      end else begin
        a_px <= ys;
        a_py <= xs;
        a_z  <= '0;
      end
    end
  end

  // Loop stages: CORDIC step k and square root digit k-1.
  logic                 l_v    [NL];
  logic                 l_zero [NL];
  logic signed [CW-1:0] l_px   [NL];
  logic signed [CW-1:0] l_py   [NL];
  logic signed [ZW-1:0] l_z    [NL];
  logic [R2W-1:0]       l_n    [NL];
  logic [RTW-1:0]       l_rem  [NL];
  logic [COORD_BITS-1:0] l_root [NL];

  for (genvar k = 0; k < NL; k++) begin : g_loop
    logic                  i_v, i_zero;
    logic signed [CW-1:0]  i_px, i_py, dx, dy;
    logic signed [ZW-1:0]  i_z;
    logic [R2W-1:0]        i_n;
    logic [RTW-1:0]        i_rem, rem_s, trial;
    logic [COORD_BITS-1:0] i_root;

    if (k == 0) begin : g_src_a
      assign i_v    = a_v;
      assign i_zero = a_zero;
      assign i_px   = a_px;
      assign i_py   = a_py;
      assign i_z    = a_z;
      assign i_n    = a_xx + a_yy;
      assign i_rem  = '0;
      assign i_root = '0;
    end else begin : g_src_l
      assign i_v    = l_v[k-1];
      assign i_zero = l_zero[k-1];
      assign i_px   = l_px[k-1];
      assign i_py   = l_py[k-1];
      assign i_z    = l_z[k-1];
      assign i_n    = l_n[k-1];
      assign i_rem  = l_rem[k-1];
      assign i_root = l_root[k-1];
    end

    assign dx    = i_py >>> (k < CORDIC_STEPS ? k : 0);
    assign dy    = i_px >>> (k < CORDIC_STEPS ? k : 0);
    assign rem_s = {i_rem[RTW-3:0], i_n[R2W-1 -: 2]};
    assign trial = RTW'({i_root, 2'b01});

    always_ff @(posedge clk) begin
      if (rst) begin
        l_v[k] <= 1'b0;
      end else if (en) begin
        l_v[k] <= i_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        l_zero[k] <= i_zero;
        if (k < CORDIC_STEPS) begin
          if (!i_py[CW-1]) begin
            l_px[k] <= i_px + dx;
            l_py[k] <= i_py - dy;
            l_z[k]  <= i_z + atan_q16(k);
          end else begin
            l_px[k] <= i_px - dx;
            l_py[k] <= i_py + dy;
            l_z[k]  <= i_z - atan_q16(k);
          end
        end else begin
          l_px[k] <= i_px;
          l_py[k] <= i_py;
          l_z[k]  <= i_z;
        end
        if (k >= 1 && k <= COORD_BITS) begin
          l_n[k] <= i_n << 2;
          if (rem_s >= trial) begin
            l_rem[k]  <= rem_s - trial;
            l_root[k] <= {i_root[COORD_BITS-2:0], 1'b1};
          end else begin
            l_rem[k]  <= rem_s;
            l_root[k] <= {i_root[COORD_BITS-2:0], 1'b0};
          end
        end else begin
          l_n[k]    <= i_n;
          l_rem[k]  <= i_rem;
          l_root[k] <= i_root;
        end
      end
    end
  end

  // Tail stages: phase product, ring parity, palette pick and blend.
  logic                          d_v, e_v, f_v, g_v, h_v, o_v;
  logic signed [PW-1:0]          d_prod;
  logic [COORD_BITS-1:0]         d_q, d_root;
  logic [IP_W-1:0]               e_ip, f_ip;
  logic [FRAC_W-1:0]             e_fr, f_fr, g_fr;
  logic [IP_W+MOD6_RECIP_W-1:0]  f_m;
  color_t                        g_c0, h_c0;
  logic signed [8:0]             g_d [3];
  logic signed [PRW-1:0]         h_p [3];
  logic [7:0]                    o_ch [3];

  logic signed [ZW-1:0]                     ang;
  logic [COORD_BITS+RING_RECIP_W-1:0]       qm;
  logic [QW-1:0]                            ring_rem;
  logic                                     parity;
  logic [FULL_W-1:0]                        full;
  logic [IP_W-1:0]                          q6, m0w;
  logic [2:0]                               m0, m1;
  color_t                                   c0, c1;
  logic signed [PRW-1:0]                    p_adj [3];

  assign ang      = l_zero[NL-1] ? '0 : l_z[NL-1];
  assign qm       = l_root[NL-1] * RING_RECIP_W'(RING_RECIP);
  assign ring_rem = QW'(d_root) - QW'(d_q) * QW'(RING_DIV);
  assign parity   = d_q[0] ^ (ring_rem >= QW'(RING_DIV));
  assign full     = FULL_W'(d_prod) + PHASE_BASE + (parity ? RING_STEP : '0) + PHASE_HALF;
  assign q6       = IP_W'(f_m >> MOD6_SHIFT);
  assign m0w      = f_ip - q6 * IP_W'(PALETTE_SIZE);
  assign m0       = m0w[2:0];
  assign m1       = (f_fr == '0) ? m0 : ((m0 == 3'(PALETTE_SIZE - 1)) ? '0 : m0 + 3'd1);
  assign c0       = pal[m0];
  assign c1       = pal[m1];

  for (genvar c = 0; c < 3; c++) begin : g_adj
    assign p_adj[c] = (h_p[c] + (h_p[c][PRW-1] ? PRW'(65535) : '0)) >>> FRAC_W;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
      e_v <= 1'b0;
      f_v <= 1'b0;
      g_v <= 1'b0;
      h_v <= 1'b0;
      o_v <= 1'b0;
    end else if (en) begin
      d_v <= l_v[NL-1];
      e_v <= d_v;
      f_v <= e_v;
      g_v <= f_v;
      h_v <= g_v;
      o_v <= h_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_prod <= PW'(ang) * PW'(K_PHASE_S);
      d_q    <= COORD_BITS'(qm >> RING_SHIFT);
      d_root <= l_root[NL-1];
      e_ip   <= full[IP_W+31:32];
      e_fr   <= full[31:16];
      f_m    <= e_ip * MOD6_RECIP_W'(MOD6_RECIP);
      f_ip   <= e_ip;
      f_fr   <= e_fr;
      g_fr   <= f_fr;
      g_c0   <= c0;
      for (int c = 0; c < 3; c++) begin
        g_d[c] <= $signed({1'b0, c1[8*(2-c) +: 8]}) - $signed({1'b0, c0[8*(2-c) +: 8]});
        h_p[c] <= PRW'(g_d[c]) * PRW'($signed({1'b0, g_fr}));
        o_ch[c] <= h_c0[8*(2-c) +: 8] + p_adj[c][7:0];
      end
      h_c0 <= g_c0;
    end
  end

  assign pix_out.valid = o_v;
  assign pix_out.red   = o_ch[0];
  assign pix_out.green = o_ch[1];
  assign pix_out.blue  = o_ch[2];

endmodule
`default_nettype wire
